[sv/hkbt_pkg.sv]
// ----------------------------------------------------------------------------
// hkbt_pkg
// Shared types and constants for the held key buffer tracker.
// ----------------------------------------------------------------------------
package hkbt_pkg;

    localparam int BUFFER_DEPTH = 16;
    localparam int IDX_W        = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1;
    localparam int CNT_W        = $clog2(BUFFER_DEPTH + 1);
    localparam int KEY_COUNT_W  = 5;
    localparam int LED_N        = 5;
    localparam int LED_SEL_W    = $clog2(LED_N);

    // func codes
    localparam logic [1:0] FUNC_RX    = 2'd0;
    localparam logic [1:0] FUNC_KEEP  = 2'd1;
    localparam logic [1:0] FUNC_RESET = 2'd2;

    localparam logic [7:0] KEY_IGNORE_MIN = 8'hC0;
    localparam logic [7:0] KEEP_MIN       = 8'h80;
    localparam logic [7:0] KEEP_MAX       = 8'h8F;
    localparam logic [7:0] CMD_RESET      = 8'hE0;
    localparam logic [7:0] CMD_LED_BASE   = 8'h40;
    localparam logic [7:0] CMD_LED_OFF    = 8'h10;

    localparam logic [7:0] KEY_CALC   = 8'h0A;
    localparam logic [7:0] KEY_SCHED  = 8'h0B;
    localparam logic [7:0] KEY_DRAW   = 8'h0C;
    localparam logic [7:0] KEY_SHLOCK = 8'h42;
    localparam logic [7:0] KEY_INSERT = 8'h5E;

    typedef struct packed {
        logic [1:0] func;
        logic [7:0] key_byte;
    } hkbt_in_t;

    typedef struct packed {
        logic                   cmd_valid;
        logic [7:0]             cmd_byte;
        logic                   key_added;
        logic                   release_missing;
        logic                   full_drop;
        logic [KEY_COUNT_W-1:0] key_count;
    } hkbt_out_t;

    typedef struct packed {
        logic       apply;
        logic [7:0] key;
    } led_req_t;

    typedef struct packed {
        logic       hit;
        logic [7:0] cmd;
    } led_resp_t;

endpackage

[sv/hkbt_led_ctrl.sv]
// ----------------------------------------------------------------------------
// hkbt_led_ctrl
// LED flag register; decodes the special keys and builds the LED command.
// ----------------------------------------------------------------------------
module hkbt_led_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  hkbt_pkg::led_req_t  req,
    output hkbt_pkg::led_resp_t resp
);
    import hkbt_pkg::*;

    logic [LED_N-1:0]     flags_reg;
    logic [LED_N-1:0]     flags_next;
    logic [LED_SEL_W-1:0] sel;
    logic [3:0]           led_code;
    logic                 hit;
    logic                 on;
    logic [7:0]           cmd;

    always_comb begin
        hit      = 1'b1;
        sel      = '0;
        led_code = 4'h0;
        unique case (req.key)
            KEY_CALC: begin
                sel      = LED_SEL_W'(0);
                led_code = 4'h7;
            end
            KEY_SCHED: begin
                sel      = LED_SEL_W'(1);
                led_code = 4'hE;
            end
            KEY_DRAW: begin
                sel      = LED_SEL_W'(2);
                led_code = 4'hD;
            end
            KEY_SHLOCK: begin
                sel      = LED_SEL_W'(3);
                led_code = 4'hB;
            end
            KEY_INSERT: begin
                sel      = LED_SEL_W'(4);
                led_code = 4'h2;
            end
            default: begin
                hit = 1'b0;
            end
        endcase
    end

    // new flag value is the inverse of the stored one
    assign on  = ~flags_reg[sel];
    assign cmd = (CMD_LED_BASE | {3'b000, led_code, on}) ^ (on ? 8'h00 : CMD_LED_OFF);

    always_comb begin
        flags_next = flags_reg;
        if (req.apply && hit) begin
            flags_next[sel] = on;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            flags_reg <= '0;
        end else begin
            flags_reg <= flags_next;
        end
    end

    assign resp.hit = hit;
    assign resp.cmd = cmd;

endmodule

[sv/hkbt_engine.sv]
// ----------------------------------------------------------------------------
// hkbt_engine
// Sequencer around the held key memory: search, append, shift and compaction.
// ----------------------------------------------------------------------------
module hkbt_engine (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                in_valid,
    output logic                in_ready,
    input  hkbt_pkg::hkbt_in_t  in_word,
    output hkbt_pkg::led_req_t  led_req,
    input  hkbt_pkg::led_resp_t led_resp,
    output logic                res_valid,
    input  logic                res_ready,
    output hkbt_pkg::hkbt_out_t res_word
);
    import hkbt_pkg::*;

    localparam logic [1:0] ST_IDLE    = 2'd0;
    localparam logic [1:0] ST_SCAN    = 2'd1;
    localparam logic [1:0] ST_COMPACT = 2'd2;
    localparam logic [1:0] ST_DONE    = 2'd3;

    logic [7:0] mem [BUFFER_DEPTH];
    logic [7:0] rdata_reg;

    logic [1:0]       state_reg, state_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [CNT_W-1:0] idx_reg, idx_next;
    logic [IDX_W-1:0] pidx_reg, pidx_next;
    logic             pend_reg, pend_next;
    logic [CNT_W-1:0] wr_reg, wr_next;
    logic [7:0]       target_reg, target_next;
    logic             rel_reg, rel_next;
    logic             keep_reg, keep_next;
    logic             cmd_valid_reg, cmd_valid_next;
    logic [7:0]       cmd_byte_reg, cmd_byte_next;
    logic             added_reg, added_next;
    logic             missing_reg, missing_next;
    logic             drop_reg, drop_next;

    logic [IDX_W-1:0] raddr;
    logic             we;
    logic [IDX_W-1:0] waddr;
    logic [7:0]       wdata;
    logic             match;
    logic             keep_word;
    logic             is_switch;
    logic [7:0]       kb;

    assign kb        = in_word.key_byte;
    assign is_switch = (kb & KEY_IGNORE_MIN) == KEEP_MIN;
    assign match     = pend_reg && (rdata_reg == target_reg);
    assign keep_word = !keep_reg || (rdata_reg >= KEEP_MIN && rdata_reg <= KEEP_MAX);

    assign in_ready      = (state_reg == ST_IDLE);
    assign led_req.apply = in_valid && in_ready && (in_word.func == FUNC_RX);
    assign led_req.key   = kb;

    always_comb begin
        state_next     = state_reg;
        count_next     = count_reg;
        idx_next       = idx_reg;
        pidx_next      = pidx_reg;
        pend_next      = pend_reg;
        wr_next        = wr_reg;
        target_next    = target_reg;
        rel_next       = rel_reg;
        keep_next      = keep_reg;
        cmd_valid_next = cmd_valid_reg;
        cmd_byte_next  = cmd_byte_reg;
        added_next     = added_reg;
        missing_next   = missing_reg;
        drop_next      = drop_reg;
        raddr          = idx_reg[IDX_W-1:0];
        we             = 1'b0;
        waddr          = wr_reg[IDX_W-1:0];
        wdata          = rdata_reg;
        res_valid      = 1'b0;

        unique case (state_reg)
            ST_IDLE: begin
                if (in_valid) begin
                    cmd_valid_next = 1'b0;
                    cmd_byte_next  = 8'h00;
                    added_next     = 1'b0;
                    missing_next   = 1'b0;
                    drop_next      = 1'b0;
                    idx_next       = '0;
                    pend_next      = 1'b0;
                    case (in_word.func)
                        FUNC_RX: begin
                            if (kb == 8'h00 || kb >= KEY_IGNORE_MIN) begin
                                state_next = ST_DONE;
                            end else begin
                                // release byte searches for its press code
                                rel_next       = is_switch && !kb[0];
                                target_next    = kb | 8'h01;
                                if (!(is_switch && !kb[0])) begin
                                    target_next = kb;
                                end
                                cmd_valid_next = led_resp.hit;
                                cmd_byte_next  = led_resp.hit ? led_resp.cmd : 8'h00;
                                state_next     = ST_SCAN;
                            end
                        end
                        FUNC_KEEP: begin
                            keep_next  = 1'b1;
                            wr_next    = '0;
                            state_next = ST_COMPACT;
                        end
                        FUNC_RESET: begin
                            count_next     = '0;
                            cmd_valid_next = 1'b1;
                            cmd_byte_next  = CMD_RESET;
                            state_next     = ST_DONE;
                        end
                        default: begin
                            state_next = ST_DONE;
                        end
                    endcase
                end
            end

            ST_SCAN: begin
                if (match) begin
                    pend_next = 1'b0;
                    if (rel_reg) begin
                        // close the gap: read from pos+1, write from pos
                        idx_next   = CNT_W'(pidx_reg) + CNT_W'(1);
                        wr_next    = CNT_W'(pidx_reg);
                        keep_next  = 1'b0;
                        state_next = ST_COMPACT;
                    end else begin
                        state_next = ST_DONE;
                    end
                end else if (idx_reg < count_reg) begin
                    pend_next = 1'b1;
                    pidx_next = idx_reg[IDX_W-1:0];
                    idx_next  = idx_reg + CNT_W'(1);
                end else begin
                    pend_next = 1'b0;
                    if (rel_reg) begin
                        missing_next = 1'b1;
                    end else if (count_reg >= CNT_W'(BUFFER_DEPTH)) begin
                        drop_next = 1'b1;
                    end else begin
                        we         = 1'b1;
                        waddr      = count_reg[IDX_W-1:0];
                        wdata      = target_reg;
                        count_next = count_reg + CNT_W'(1);
                        added_next = 1'b1;
                    end
                    state_next = ST_DONE;
                end
            end

            ST_COMPACT: begin
                // write address always trails the read address
                if (pend_reg && keep_word) begin
                    we      = 1'b1;
                    wr_next = wr_reg + CNT_W'(1);
                end
                if (idx_reg < count_reg) begin
                    pend_next = 1'b1;
                    pidx_next = idx_reg[IDX_W-1:0];
                    idx_next  = idx_reg + CNT_W'(1);
                end else begin
                    pend_next = 1'b0;
                    if (!pend_reg) begin
                        count_next = wr_reg;
                        state_next = ST_DONE;
                    end
                end
            end

            ST_DONE: begin
                res_valid = 1'b1;
                if (res_ready) begin
                    state_next = ST_IDLE;
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            count_reg <= '0;
            pend_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
            pend_reg  <= pend_next;
        end
    end

    always_ff @(posedge aclk) begin
        idx_reg       <= idx_next;
        pidx_reg      <= pidx_next;
        wr_reg        <= wr_next;
        target_reg    <= target_next;
        rel_reg       <= rel_next;
        keep_reg      <= keep_next;
        cmd_valid_reg <= cmd_valid_next;
        cmd_byte_reg  <= cmd_byte_next;
        added_reg     <= added_next;
        missing_reg   <= missing_next;
        drop_reg      <= drop_next;
    end

    assign res_word.cmd_valid       = cmd_valid_reg;
    assign res_word.cmd_byte        = cmd_byte_reg;
    assign res_word.key_added       = added_reg;
    assign res_word.release_missing = missing_reg;
    assign res_word.full_drop       = drop_reg;
    assign res_word.key_count       = KEY_COUNT_W'(count_reg);

endmodule

[sv/held_key_buffer_tracker_unit.sv]
// ----------------------------------------------------------------------------
// held_key_buffer_tracker_unit
// Tracks held keys from scancode words; one result word per input word.
// ----------------------------------------------------------------------------
// Ignored bytes, reset and unused func finish without a walk over the key memory;
//   searches, releases and keep passes walk it through its one read port.
// Flow: one word in work at a time; the next word is taken while the
//   previous result waits in the output register.
// Reset: synchronous, active low; empties the buffer and clears the LED flags.
//   The key memory is not cleared; only entries below the count are read.
module held_key_buffer_tracker_unit (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  hkbt_pkg::hkbt_in_t  s_word,
    output logic                m_valid,
    input  logic                m_ready,
    output hkbt_pkg::hkbt_out_t m_word
);
    import hkbt_pkg::*;

    led_req_t  led_req;
    led_resp_t led_resp;
    logic      res_valid;
    logic      res_ready;
    hkbt_out_t res_word;

    logic      m_valid_reg;
    hkbt_out_t m_word_reg;

    hkbt_led_ctrl u_led (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (led_req),
        .resp    (led_resp)
    );

    hkbt_engine u_engine (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_valid),
        .in_ready  (s_ready),
        .in_word   (s_word),
        .led_req   (led_req),
        .led_resp  (led_resp),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res_word  (res_word)
    );

    assign res_ready = !m_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (res_valid && res_ready) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_valid && res_ready) begin
            m_word_reg <= res_word;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_word  = m_word_reg;

endmodule

[sv/hkbt_checker.sv]
// ----------------------------------------------------------------------------
// hkbt_checker
// Port-level checks for the held key buffer tracker, bound to the top level.
// ----------------------------------------------------------------------------
module hkbt_checker (
    input logic                aclk,
    input logic                aresetn,
    input logic                s_valid,
    input logic                s_ready,
    input hkbt_pkg::hkbt_in_t  s_word,
    input logic                m_valid,
    input logic                m_ready,
    input hkbt_pkg::hkbt_out_t m_word
);
    import hkbt_pkg::*;

    // an offered input word holds until taken
    a_in_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && !s_ready |=> s_valid && $stable(s_word))
        else $error("input word changed before accept");

    // a stalled result word holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_word))
        else $error("result word changed while stalled");

    // at most one outcome flag per word
    a_one_outcome: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> $countones({m_word.key_added, m_word.release_missing,
                                m_word.full_drop}) <= 1)
        else $error("more than one outcome flag");

    a_cmd_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_word.cmd_valid |-> m_word.cmd_byte == 8'h00)
        else $error("command byte without command valid");

    // missing releases never raise an LED command
    a_release_no_cmd: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_word.release_missing |-> !m_word.cmd_valid)
        else $error("command on a missing release");

endmodule

bind held_key_buffer_tracker_unit hkbt_checker u_hkbt_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .s_word  (s_word),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_word  (m_word)
);

[tb/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the held key buffer tracker. A behavioral tracker
// predicts each result word; directed corner cases, a full-buffer pass and random
// key traffic run, the random traffic under several sender/receiver idle mixes.
// ----------------------------------------------------------------------------
module tb_top;
    import hkbt_pkg::*;

    localparam logic [1:0] FUNC_UNUSED = 2'd3;
    localparam logic [3:0] LED_CALC    = 4'h7;
    localparam logic [3:0] LED_SCHED   = 4'hE;
    localparam logic [3:0] LED_DRAW    = 4'hD;
    localparam logic [3:0] LED_SHLOCK  = 4'hB;
    localparam logic [3:0] LED_INSERT  = 4'h2;
    localparam int RANDOM_PER_PHASE    = 105;
    localparam int SETTLE_CYCLES       = 60;
    localparam int STOP_AFTER_NS       = 5_000_000;

    logic      aclk    = 1'b0;
    logic      aresetn = 1'b0;
    logic      s_valid = 1'b0;
    logic      s_ready;
    hkbt_in_t  s_word  = '0;
    logic      m_valid;
    logic      m_ready = 1'b0;
    hkbt_out_t m_word;

    held_key_buffer_tracker_unit u_top (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_word  (s_word),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_word  (m_word)
    );

    always begin
        aclk = 1'b1;
        #6;
        aclk = 1'b0;
        #6;
    end

    // Tracker state mirrored by the bench
    logic [7:0] held_q [BUFFER_DEPTH];
    int         held_n;
    logic [4:0] led_state;

    hkbt_out_t  expected_words[$];
    int         idle_pct;
    int         stall_pct;
    int         errors;
    int         words_sent;
    int         words_checked;
    int         n_added;
    int         n_dropped;
    int         n_missing;
    int         n_cmds;
    int         max_held;

    always @(negedge aclk) begin
        m_ready <= ($urandom_range(0, 99) >= stall_pct);
    end

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("MISMATCH result %0d %s: got 0x%0h want 0x%0h",
                 words_checked, what, got, want);
        errors++;
    endtask

    function automatic int find_held(input logic [7:0] k);
        for (int i = 0; i < held_n; i++) begin
            if (held_q[i] == k) return i;
        end
        return -1;
    endfunction

    function automatic void append_key(input logic [7:0] k, inout hkbt_out_t r);
        if (find_held(k) >= 0) return;
        if (held_n >= BUFFER_DEPTH) begin
            r.full_drop = 1'b1;
            return;
        end
        held_q[held_n] = k;
        held_n++;
        r.key_added = 1'b1;
    endfunction

    function automatic logic [7:0] led_toggle(input int idx, input logic [3:0] code);
        logic       on;
        logic [7:0] cmd;
        led_state[idx] = ~led_state[idx];
        on  = led_state[idx];
        cmd = CMD_LED_BASE | {3'b000, code, 1'b0} | {7'b0, on};
        if (!on) cmd = cmd ^ CMD_LED_OFF;
        return cmd;
    endfunction

    function automatic hkbt_out_t track_held_keys(input hkbt_in_t w);
        hkbt_out_t r;
        int        pos;
        int        kept;
        r = '0;
        case (w.func)
            FUNC_RX: begin
                if (w.key_byte == 8'h00 || w.key_byte >= KEY_IGNORE_MIN) begin
                    // ignored byte
                end else if (w.key_byte[7:6] == 2'b10 && !w.key_byte[0]) begin
                    // switch release: drop the matching press, close the gap
                    pos = find_held(w.key_byte | 8'h01);
                    if (pos < 0) begin
                        r.release_missing = 1'b1;
                    end else begin
                        for (int i = pos; i < held_n - 1; i++) held_q[i] = held_q[i + 1];
                        held_n--;
                    end
                end else begin
                    append_key(w.key_byte, r);
                    case (w.key_byte)
                        KEY_CALC: begin
                            r.cmd_valid = 1'b1;
                            r.cmd_byte  = led_toggle(0, LED_CALC);
                        end
                        KEY_SCHED: begin
                            r.cmd_valid = 1'b1;
                            r.cmd_byte  = led_toggle(1, LED_SCHED);
                        end
                        KEY_DRAW: begin
                            r.cmd_valid = 1'b1;
                            r.cmd_byte  = led_toggle(2, LED_DRAW);
                        end
                        KEY_SHLOCK: begin
                            r.cmd_valid = 1'b1;
                            r.cmd_byte  = led_toggle(3, LED_SHLOCK);
                        end
                        KEY_INSERT: begin
                            r.cmd_valid = 1'b1;
                            r.cmd_byte  = led_toggle(4, LED_INSERT);
                        end
                        default: ;
                    endcase
                end
            end
            FUNC_KEEP: begin
                kept = 0;
                for (int i = 0; i < held_n; i++) begin
                    if (held_q[i] >= KEEP_MIN && held_q[i] <= KEEP_MAX) begin
                        held_q[kept] = held_q[i];
                        kept++;
                    end
                end
                held_n = kept;
            end
            FUNC_RESET: begin
                held_n      = 0;
                r.cmd_valid = 1'b1;
                r.cmd_byte  = CMD_RESET;
            end
            default: ;
        endcase
        r.key_count = KEY_COUNT_W'(held_n);
        if (held_n > max_held) max_held = held_n;
        return r;
    endfunction

    always @(posedge aclk) begin : check_results
        hkbt_out_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_words.size() == 0) begin
                report_mismatch("unexpected word", int'(m_word), 0);
            end else begin
                want = expected_words.pop_front();
                if (m_word.cmd_valid != want.cmd_valid)
                    report_mismatch("cmd_valid", int'(m_word.cmd_valid),
                                    int'(want.cmd_valid));
                if (m_word.cmd_byte != want.cmd_byte)
                    report_mismatch("cmd_byte", int'(m_word.cmd_byte),
                                    int'(want.cmd_byte));
                if (m_word.key_added != want.key_added)
                    report_mismatch("key_added", int'(m_word.key_added),
                                    int'(want.key_added));
                if (m_word.release_missing != want.release_missing)
                    report_mismatch("release_missing", int'(m_word.release_missing),
                                    int'(want.release_missing));
                if (m_word.full_drop != want.full_drop)
                    report_mismatch("full_drop", int'(m_word.full_drop),
                                    int'(want.full_drop));
                if (m_word.key_count != want.key_count)
                    report_mismatch("key_count", int'(m_word.key_count),
                                    int'(want.key_count));
                n_added   += int'(want.key_added);
                n_dropped += int'(want.full_drop);
                n_missing += int'(want.release_missing);
                n_cmds    += int'(want.cmd_valid);
            end
            words_checked++;
        end
    end

    // Called just after a falling edge; returns just after a falling edge.
    task automatic send_word(input logic [1:0] func, input logic [7:0] key);
        hkbt_in_t w;
        w.func     = func;
        w.key_byte = key;
        while ($urandom_range(0, 99) < idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_word  <= w;
        do @(posedge aclk); while (!s_ready);
        expected_words.push_back(track_held_keys(w));
        words_sent++;
        @(negedge aclk);
    endtask

    // Sender holds off until every outstanding result has come back.
    task automatic wait_drained();
        s_valid <= 1'b0;
        do @(negedge aclk); while (expected_words.size() != 0);
    endtask

    task automatic test_corner_cases();
        idle_pct  = 0;
        stall_pct = 0;
        send_word(FUNC_RX, 8'h00);
        send_word(FUNC_RX, KEY_IGNORE_MIN);
        send_word(FUNC_RX, 8'hFF);
        send_word(FUNC_UNUSED, 8'hFF);
        send_word(FUNC_RX, 8'h81);
        send_word(FUNC_RX, 8'h81);          // already held
        send_word(FUNC_RX, 8'hBF);
        send_word(FUNC_RX, 8'h80);          // release of 0x81
        send_word(FUNC_RX, 8'h80);          // nothing left to release
        send_word(FUNC_RX, 8'hBE);
        send_word(FUNC_RX, 8'h01);
        send_word(FUNC_RX, 8'h7F);
        send_word(FUNC_RX, 8'h01);
        send_word(FUNC_RX, KEY_CALC);
        send_word(FUNC_RX, KEY_SCHED);
        send_word(FUNC_RX, KEY_DRAW);
        send_word(FUNC_RX, KEY_SHLOCK);
        send_word(FUNC_RX, KEY_INSERT);
        send_word(FUNC_RX, KEY_CALC);       // held already, LED goes off
        send_word(FUNC_RX, 8'h8F);
        send_word(FUNC_RX, 8'h91);
        send_word(FUNC_KEEP, 8'h00);
        send_word(FUNC_RESET, 8'hA5);
        wait_drained();
    endtask

    task automatic test_full_buffer();
        int base;
        idle_pct  = 14;
        stall_pct = 14;
        base      = $urandom_range(0, 126);
        send_word(FUNC_RESET, 8'h00);
        for (int i = 0; i < BUFFER_DEPTH; i++) begin
            if (i == 7) send_word(FUNC_RX, 8'h83);
            else send_word(FUNC_RX, 8'(((base + i) % 127) + 1));
        end
        send_word(FUNC_RX, 8'(((base + BUFFER_DEPTH) % 127) + 1));
        send_word(FUNC_RX, KEY_INSERT);
        send_word(FUNC_RX, 8'h85);
        send_word(FUNC_RX, 8'h82);          // frees a slot in the middle
        send_word(FUNC_RX, 8'h85);
        send_word(FUNC_KEEP, 8'hFF);
        wait_drained();
    endtask

    task automatic test_random_traffic(input int send_idle, input int recv_stall);
        int         pick;
        int         idx;
        int         counted;
        logic [1:0] func;
        logic [7:0] key;
        idle_pct  = send_idle;
        stall_pct = recv_stall;
        counted   = 0;
        while (counted < RANDOM_PER_PHASE) begin
            func = FUNC_RX;
            key  = 8'($urandom_range(0, 255));
            pick = $urandom_range(0, 99);
            if (pick < 2) begin
                func = FUNC_RESET;
            end else if (pick < 6) begin
                func = FUNC_KEEP;
            end else if (pick < 8) begin
                func = FUNC_UNUSED;
            end else if (pick < 16) begin
                key = ($urandom_range(0, 3) == 0) ? 8'h00 : 8'($urandom_range(8'hC0, 8'hFF));
            end else if (pick < 40) begin
                key = {2'b10, 6'($urandom_range(0, 63))} | 8'h01;
            end else if (pick < 60) begin
                // mostly releases of held switches, sometimes stray ones
                idx = (held_n > 0) ? $urandom_range(0, held_n - 1) : 0;
                if (held_n > 0 && held_q[idx][7:6] == 2'b10 && $urandom_range(0, 4) != 0)
                    key = held_q[idx] & 8'hFE;
                else
                    key = {2'b10, 6'($urandom_range(0, 63))} & 8'hFE;
            end else if (pick < 70) begin
                case ($urandom_range(0, 4))
                    0: key = KEY_CALC;
                    1: key = KEY_SCHED;
                    2: key = KEY_DRAW;
                    3: key = KEY_SHLOCK;
                    default: key = KEY_INSERT;
                endcase
            end else begin
                key = 8'($urandom_range(1, 127));
            end
            send_word(func, key);
            if (!(func == FUNC_RX && (key == 8'h00 || key >= KEY_IGNORE_MIN))) counted++;
        end
        wait_drained();
    endtask

    initial begin
        for (int i = 0; i < BUFFER_DEPTH; i++) held_q[i] = '0;
        held_n    = 0;
        led_state = '0;
        idle_pct  = 0;
        stall_pct = 0;
        errors    = 0;
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        test_corner_cases();
        test_full_buffer();
        test_random_traffic(0, 0);
        test_random_traffic(51, 0);
        test_random_traffic(0, 51);
        test_random_traffic(14, 14);

        repeat (SETTLE_CYCLES) @(posedge aclk);
        $display("Sent %0d words, checked %0d results: %0d adds, %0d full drops,",
                 words_sent, words_checked, n_added, n_dropped);
        $display("%0d missing releases, %0d keyboard commands, peak buffer fill %0d",
                 n_missing, n_cmds, max_held);
        if (errors == 0 && expected_words.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

    initial begin
        #(STOP_AFTER_NS);
        $display("Timeout with %0d results outstanding", expected_words.size());
        $display("RESULT: ERROR");
        $finish;
    end

endmodule

[filelist.f]
sv/hkbt_pkg.sv
sv/hkbt_led_ctrl.sv
sv/hkbt_engine.sv
sv/held_key_buffer_tracker_unit.sv
sv/hkbt_checker.sv
tb/tb_top.sv
